>>> sv/ptpob_pkg.sv
// ---------------------------------------------------------------------------
// ptpob_pkg
// shared types, codes and defaults of the price-time priority order book
// ---------------------------------------------------------------------------
package ptpob_pkg;

  localparam int BOOK_DEPTH_DEF = 256;
  localparam int MKT_DEPTH_DEF  = 64;
  localparam int SEQ_W          = 48;
  localparam int CNT_W          = 9;

  localparam logic [2:0] CMD_ADD_LIMIT  = 3'd0;
  localparam logic [2:0] CMD_ADD_MARKET = 3'd1;
  localparam logic [2:0] CMD_POP_BID    = 3'd2;
  localparam logic [2:0] CMD_POP_ASK    = 3'd3;
  localparam logic [2:0] CMD_POP_BUY    = 3'd4;
  localparam logic [2:0] CMD_POP_SELL   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // resting limit order, seq breaks exact price and time ties
  typedef struct packed {
    logic [31:0]      id;
    logic [31:0]      px;
    logic [47:0]      ts;
    logic [SEQ_W-1:0] seq;
  } hp_entry_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] px;
    logic [47:0] ts;
  } mk_entry_t;

  // x strictly ahead of y in the bid store (asks = 0) or ask store (asks = 1)
  function automatic logic outranks(logic asks, hp_entry_t x, hp_entry_t y);
    logic r;
    if (x.px != y.px) begin
      r = asks ? (x.px < y.px) : (x.px > y.px);
    end else if (x.ts != y.ts) begin
      r = x.ts < y.ts;
    end else begin
      r = x.seq < y.seq;
    end
    return r;
  endfunction

endpackage

>>> sv/price_time_priority_order_book_unit.sv
// ---------------------------------------------------------------------------
// price_time_priority_order_book_unit
// bid and ask binary heaps plus buy and sell market fifos, all in ram
// ---------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid / in_ready     command side order_id price time_stamp
// out      output     out_valid / out_ready   status order_valid out_* counts can_match
//
// one command at a time; in_ready is high while the sequencer is idle
// limit add: the new entry walks up the heap, a heap ram read and a compare per level
// limit pop: the last entry walks down from the root, two child reads per level, no walk for a last entry
// market add/pop and rejected commands: no heap walk
// a finished result waits in the output register; the next command is taken meanwhile
// synchronous reset clears counts and pointers; ram contents are never cleared
// ---------------------------------------------------------------------------
module price_time_priority_order_book_unit
  import ptpob_pkg::*;
#(
  parameter int BOOK_DEPTH        = BOOK_DEPTH_DEF,
  parameter int MARKET_FIFO_DEPTH = MKT_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       command,
  input  logic             side,
  input  logic [31:0]      order_id,
  input  logic [31:0]      price,
  input  logic [47:0]      time_stamp,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic             order_valid,
  output logic [31:0]      out_order_id,
  output logic [31:0]      out_price,
  output logic [47:0]      out_time_stamp,
  output logic             out_side,
  output logic [CNT_W-1:0] bid_count,
  output logic [CNT_W-1:0] ask_count,
  output logic             can_match
);

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = AW + 1;
  localparam int IW = AW + 2;
  localparam int FW = $clog2(MARKET_FIFO_DEPTH);
  localparam int FC = FW + 1;
  localparam logic [CW-1:0] BOOK_FULL = CW'(BOOK_DEPTH);
  localparam logic [FC-1:0] FIFO_FULL = FC'(MARKET_FIFO_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CHK, S_UP_CMP, S_POP_R0, S_POP_R1, S_POP_R2,
    S_DN_CHK, S_DN_L, S_DN_R, S_DN_CMP, S_FIFO_RD, S_FIFO_CAP,
    S_TOP_RD, S_TOP_CAP, S_FIN
  } state_t;

  state_t           state;
  logic             sel;
  logic             fsel;
  hp_entry_t        nw;
  hp_entry_t        x;
  hp_entry_t        c;
  logic [AW-1:0]    pos;
  logic [AW-1:0]    cidx;
  logic [CW-1:0]    bid_fill;
  logic [CW-1:0]    ask_fill;
  logic [SEQ_W-1:0] seq;
  logic [FW-1:0]    head [2];
  logic [FC-1:0]    cnt  [2];
  logic [31:0]      bid_top;
  logic [31:0]      ask_top;
  logic [1:0]       res_status;
  logic             res_valid;
  logic             res_side;
  mk_entry_t        res;

  // heap ram ports
  logic            heap_we;
  logic [AW-1:0]   heap_wa;
  hp_entry_t       heap_wd;
  logic [AW-1:0]   heap_ra;
  hp_entry_t       bid_q;
  hp_entry_t       ask_q;
  hp_entry_t       heap_q;
  // fifo ram ports
  logic            fifo_we;
  logic [FW-1:0]   fifo_wa;
  mk_entry_t       fifo_wd;
  mk_entry_t       buy_q;
  mk_entry_t       sell_q;
  mk_entry_t       fifo_q;

  logic [CW-1:0]   fill_cur;
  logic [IW-1:0]   l_idx;
  logic [IW-1:0]   r_idx;
  logic [AW-1:0]   parent;
  logic [FW:0]     slot_sum;
  logic [FW-1:0]   slot;

  assign in_ready = (state == S_IDLE);
  assign heap_q   = sel ? ask_q : bid_q;
  assign fifo_q   = fsel ? sell_q : buy_q;
  assign fill_cur = sel ? ask_fill : bid_fill;
  assign l_idx    = IW'({pos, 1'b1});
  assign r_idx    = l_idx + IW'(1);
  assign parent   = AW'((pos - AW'(1)) >> 1);

  // market add slot wraps round the fifo depth
  assign slot_sum = (FW + 1)'(head[side]) + (FW + 1)'(cnt[side]);
  assign slot     = (slot_sum >= (FW + 1)'(MARKET_FIFO_DEPTH))
                    ? FW'(slot_sum - (FW + 1)'(MARKET_FIFO_DEPTH)) : FW'(slot_sum);

  always_comb begin
    heap_we = 1'b0;
    heap_wa = pos;
    heap_wd = nw;
    heap_ra = '0;
    case (state)
      S_UP_CHK: begin
        if (pos == '0) begin
          heap_we = 1'b1;
        end
        heap_ra = parent;
      end
      S_UP_CMP: begin
        heap_we = 1'b1;
        heap_wd = outranks(sel, nw, heap_q) ? heap_q : nw;
      end
      S_POP_R1: heap_ra = AW'(fill_cur - CW'(1));
      S_DN_CHK: begin
        if (l_idx >= IW'(fill_cur)) begin
          heap_we = 1'b1;
          heap_wd = x;
        end
        heap_ra = AW'(l_idx);
      end
      S_DN_L: heap_ra = AW'(r_idx);
      S_DN_CMP: begin
        heap_we = 1'b1;
        heap_wd = outranks(sel, c, x) ? c : x;
      end
      default: heap_ra = '0;
    endcase
  end

  always_comb begin
    fifo_we = in_valid && in_ready && (command == CMD_ADD_MARKET) && (cnt[side] != FIFO_FULL);
    fifo_wa = slot;
    fifo_wd = '{id: order_id, px: price, ts: time_stamp};
  end

  ptpob_ram #(.WIDTH($bits(hp_entry_t)), .DEPTH(BOOK_DEPTH)) u_bid_ram (
    .clk(clk), .we(heap_we && !sel), .wa(heap_wa), .wd(heap_wd), .ra(heap_ra), .rd(bid_q)
  );

  ptpob_ram #(.WIDTH($bits(hp_entry_t)), .DEPTH(BOOK_DEPTH)) u_ask_ram (
    .clk(clk), .we(heap_we && sel), .wa(heap_wa), .wd(heap_wd), .ra(heap_ra), .rd(ask_q)
  );

  ptpob_ram #(.WIDTH($bits(mk_entry_t)), .DEPTH(MARKET_FIFO_DEPTH)) u_buy_ram (
    .clk(clk), .we(fifo_we && !side), .wa(fifo_wa), .wd(fifo_wd), .ra(head[0]), .rd(buy_q)
  );

  ptpob_ram #(.WIDTH($bits(mk_entry_t)), .DEPTH(MARKET_FIFO_DEPTH)) u_sell_ram (
    .clk(clk), .we(fifo_we && side), .wa(fifo_wa), .wd(fifo_wd), .ra(head[1]), .rd(sell_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bid_fill  <= '0;
      ask_fill  <= '0;
      seq       <= '0;
      head[0]   <= '0;
      head[1]   <= '0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      out_valid <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            nw         <= '{id: order_id, px: price, ts: time_stamp, seq: seq};
            res_status <= ST_OK;
            res_valid  <= 1'b0;
            res_side   <= 1'b0;
            res        <= '0;
            state      <= S_FIN;
            case (command)
              CMD_ADD_LIMIT: begin
                sel <= side;
                if ((side ? ask_fill : bid_fill) == BOOK_FULL) begin
                  res_status <= ST_FULL;
                end else begin
                  pos <= AW'(side ? ask_fill : bid_fill);
                  if (side) begin
                    ask_fill <= ask_fill + CW'(1);
                  end else begin
                    bid_fill <= bid_fill + CW'(1);
                  end
                  seq   <= seq + SEQ_W'(1);
                  state <= S_UP_CHK;
                end
              end
              CMD_ADD_MARKET: begin
                if (cnt[side] == FIFO_FULL) begin
                  res_status <= ST_FULL;
                end else begin
                  cnt[side] <= cnt[side] + FC'(1);
                end
              end
              CMD_POP_BID, CMD_POP_ASK: begin
                sel <= (command == CMD_POP_ASK);
                if (((command == CMD_POP_ASK) ? ask_fill : bid_fill) == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_POP_R0;
                end
              end
              CMD_POP_BUY, CMD_POP_SELL: begin
                fsel <= (command == CMD_POP_SELL);
                if (cnt[command == CMD_POP_SELL] == '0) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_FIFO_RD;
                end
              end
              default: res_status <= ST_OK;
            endcase
          end
        end
        S_UP_CHK: begin
          state <= (pos == '0) ? S_TOP_RD : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (outranks(sel, nw, heap_q)) begin
            pos   <= parent;
            state <= S_UP_CHK;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_POP_R0: state <= S_POP_R1;
        S_POP_R1: begin
          res       <= '{id: heap_q.id, px: heap_q.px, ts: heap_q.ts};
          res_valid <= 1'b1;
          res_side  <= sel;
          state     <= S_POP_R2;
        end
        S_POP_R2: begin
          // last entry moves to the root and sifts down
          x   <= heap_q;
          pos <= '0;
          if (sel) begin
            ask_fill <= ask_fill - CW'(1);
          end else begin
            bid_fill <= bid_fill - CW'(1);
          end
          state <= (fill_cur == CW'(1)) ? S_TOP_RD : S_DN_CHK;
        end
        S_DN_CHK: begin
          state <= (l_idx >= IW'(fill_cur)) ? S_TOP_RD : S_DN_L;
        end
        S_DN_L: begin
          c     <= heap_q;
          cidx  <= AW'(l_idx);
          state <= (r_idx < IW'(fill_cur)) ? S_DN_R : S_DN_CMP;
        end
        S_DN_R: begin
          if (outranks(sel, heap_q, c)) begin
            c    <= heap_q;
            cidx <= AW'(r_idx);
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (outranks(sel, c, x)) begin
            pos   <= cidx;
            state <= S_DN_CHK;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_FIFO_RD: state <= S_FIFO_CAP;
        S_FIFO_CAP: begin
          res        <= fifo_q;
          res_valid  <= 1'b1;
          res_side   <= fsel;
          head[fsel] <= (head[fsel] == FW'(MARKET_FIFO_DEPTH - 1))
                        ? '0 : head[fsel] + FW'(1);
          cnt[fsel]  <= cnt[fsel] - FC'(1);
          state      <= S_FIN;
        end
        S_TOP_RD: state <= S_TOP_CAP;
        S_TOP_CAP: begin
          bid_top <= bid_q.px;
          ask_top <= ask_q.px;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            status         <= res_status;
            order_valid    <= res_valid;
            out_order_id   <= res.id;
            out_price      <= res.px;
            out_time_stamp <= res.ts;
            out_side       <= res_side;
            bid_count      <= CNT_W'(bid_fill);
            ask_count      <= CNT_W'(ask_fill);
            can_match      <= (bid_fill != '0) && (ask_fill != '0) && (bid_top >= ask_top);
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a popped order always comes with an ok status
  a_valid_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && order_valid |-> status == ST_OK)
    else $error("popped order with bad status");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    bid_fill <= BOOK_FULL && ask_fill <= BOOK_FULL)
    else $error("heap fill beyond depth");

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= FIFO_FULL && cnt[1] <= FIFO_FULL)
    else $error("fifo count beyond depth");

  // a new result only appears on leaving the final state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result outside final state");

endmodule

>>> sv/ptpob_ram.sv
// ---------------------------------------------------------------------------
// ptpob_ram
// simple dual-port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module ptpob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

>>> dv/price_time_priority_order_book_unit_tb.sv
// ---------------------------------------------------------------------------
// price_time_priority_order_book_unit_tb
// directed table then random command streams against an in-bench book model
// ---------------------------------------------------------------------------
module price_time_priority_order_book_unit_tb;
  import ptpob_pkg::*;

  localparam int BOOK_N   = 256;
  localparam int MKT_N    = 64;
  localparam int N_RANDOM = 1830;
  localparam int MAX_CYC  = 2000000;

  typedef struct {
    logic [31:0] id;
    logic [31:0] px;
    logic [47:0] ts;
  } book_order_t;

  typedef struct {
    logic [1:0]  st;
    logic        ov;
    logic [31:0] id;
    logic [31:0] px;
    logic [47:0] ts;
    logic        sd;
    logic [8:0]  bc;
    logic [8:0]  ac;
    logic        cm;
  } book_result_t;

  typedef struct {
    logic [2:0]  cmd;
    logic        sd;
    logic [31:0] id;
    logic [31:0] px;
    logic [47:0] ts;
    logic        typed;
    logic [1:0]  st;
    logic [8:0]  bc;
    logic [8:0]  ac;
  } cmd_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] command = '0;
  logic side = 0;
  logic [31:0] order_id = '0;
  logic [31:0] price = '0;
  logic [47:0] time_stamp = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] status;
  logic order_valid;
  logic [31:0] out_order_id;
  logic [31:0] out_price;
  logic [47:0] out_time_stamp;
  logic out_side;
  logic [CNT_W-1:0] bid_count;
  logic [CNT_W-1:0] ask_count;
  logic can_match;

  price_time_priority_order_book_unit dut (.*);

  always #5 clk = ~clk;

  // book state, limit stores kept sorted best first, market fifos in arrival order
  book_order_t bids[$];
  book_order_t asks[$];
  book_order_t mkt_buy[$];
  book_order_t mkt_sell[$];
  book_result_t pending[$];

  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic bit ahead(bit is_ask, book_order_t x, book_order_t y);
    if (x.px != y.px) return is_ask ? (x.px < y.px) : (x.px > y.px);
    return x.ts < y.ts;
  endfunction

  function automatic book_result_t book_apply(cmd_row_t r);
    book_result_t res;
    book_order_t o;
    int p;
    res = '{default: '0};
    o = '{id: r.id, px: r.px, ts: r.ts};
    case (r.cmd)
      CMD_ADD_LIMIT: begin
        if (r.sd) begin
          if (asks.size() >= BOOK_N) res.st = ST_FULL;
          else begin
            p = 0;
            while (p < asks.size() && !ahead(1, o, asks[p])) p++;
            asks.insert(p, o);
          end
        end else begin
          if (bids.size() >= BOOK_N) res.st = ST_FULL;
          else begin
            p = 0;
            while (p < bids.size() && !ahead(0, o, bids[p])) p++;
            bids.insert(p, o);
          end
        end
      end
      CMD_ADD_MARKET: begin
        if (r.sd) begin
          if (mkt_sell.size() >= MKT_N) res.st = ST_FULL;
          else mkt_sell.push_back(o);
        end else begin
          if (mkt_buy.size() >= MKT_N) res.st = ST_FULL;
          else mkt_buy.push_back(o);
        end
      end
      CMD_POP_BID, CMD_POP_BUY: begin
        if (r.cmd == CMD_POP_BID ? bids.size() == 0 : mkt_buy.size() == 0) res.st = ST_EMPTY;
        else begin
          o = (r.cmd == CMD_POP_BID) ? bids.pop_front() : mkt_buy.pop_front();
          res.ov = 1'b1; res.id = o.id; res.px = o.px; res.ts = o.ts; res.sd = 1'b0;
        end
      end
      CMD_POP_ASK, CMD_POP_SELL: begin
        if (r.cmd == CMD_POP_ASK ? asks.size() == 0 : mkt_sell.size() == 0) res.st = ST_EMPTY;
        else begin
          o = (r.cmd == CMD_POP_ASK) ? asks.pop_front() : mkt_sell.pop_front();
          res.ov = 1'b1; res.id = o.id; res.px = o.px; res.ts = o.ts; res.sd = 1'b1;
        end
      end
      default: ;
    endcase
    res.bc = 9'(bids.size());
    res.ac = 9'(asks.size());
    res.cm = bids.size() > 0 && asks.size() > 0 && bids[0].px >= asks[0].px;
    return res;
  endfunction

  // valid stays high from one transfer to the next unless the sender idles
  task automatic send_cmd(cmd_row_t r);
    book_result_t res;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    command <= r.cmd; side <= r.sd; order_id <= r.id; price <= r.px; time_stamp <= r.ts;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    res = book_apply(r);
    if (r.typed && (res.st != r.st || res.bc != r.bc || res.ac != r.ac)) begin
      $error("table row disagrees with model: status %0d counts %0d/%0d", res.st, res.bc,
             res.ac);
      errors++;
    end
    if (r.typed) begin
      res.st = r.st; res.bc = r.bc; res.ac = r.ac;
    end
    pending.push_back(res);
  endtask

  task automatic chk(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h actual %0h", name, e, a);
      errors++;
    end
  endtask

  // receiver and result check
  always @(posedge clk) begin
    book_result_t e;
    if (!rst) begin
      out_ready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        if (pending.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          e = pending.pop_front();
          chk("status", e.st, status);
          chk("order_valid", e.ov, order_valid);
          chk("out_order_id", e.id, out_order_id);
          chk("out_price", e.px, out_price);
          chk("out_time_stamp", e.ts, out_time_stamp);
          chk("out_side", e.sd, out_side);
          chk("bid_count", e.bc, bid_count);
          chk("ask_count", e.ac, ask_count);
          chk("can_match", e.cm, can_match);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYC) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic cmd_row_t row(logic [2:0] c, logic s, logic [31:0] i, logic [31:0] p,
                                   logic [47:0] t);
    return '{cmd: c, sd: s, id: i, px: p, ts: t, typed: 0, st: ST_OK, bc: 0, ac: 0};
  endfunction

  function automatic cmd_row_t trow(logic [2:0] c, logic [1:0] st, logic [8:0] bc,
                                    logic [8:0] ac);
    return '{cmd: c, sd: 1, id: '1, px: '1, ts: '1, typed: 1, st: st, bc: bc, ac: ac};
  endfunction

  cmd_row_t directed[$];
  cmd_row_t r;
  int n_fill;
  int k;
  logic [31:0] px_base;
  logic fill_side;

  initial begin
    // empty pops right after reset, unknown commands, extremes, ties
    directed = '{
      trow(CMD_POP_BID, ST_EMPTY, 0, 0), trow(CMD_POP_ASK, ST_EMPTY, 0, 0),
      trow(CMD_POP_BUY, ST_EMPTY, 0, 0), trow(CMD_POP_SELL, ST_EMPTY, 0, 0),
      trow(3'd6, ST_OK, 0, 0), trow(3'd7, ST_OK, 0, 0),
      row(CMD_ADD_LIMIT, 0, 32'h1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF),
      row(CMD_ADD_LIMIT, 0, 32'h2, 32'hFFFF_FFFF, 48'h0),
      row(CMD_ADD_LIMIT, 0, 32'h3, 32'hFFFF_FFFF, 48'h0),
      row(CMD_ADD_LIMIT, 1, 32'hFFFF_FFFF, 32'h0, 48'h5),
      row(CMD_ADD_LIMIT, 1, 32'h0, 32'h0, 48'h5),
      row(CMD_ADD_MARKET, 0, 32'hAAAA_5555, 32'h1234, 48'hAAAA_5555_AAAA),
      row(CMD_ADD_MARKET, 1, 32'h5555_AAAA, 32'hFFFF_FFFF, 48'h5555_AAAA_5555),
      row(CMD_POP_BID, 1, 0, 0, 0), row(CMD_POP_BID, 0, 0, 0, 0),
      row(CMD_POP_ASK, 0, 0, 0, 0), row(CMD_POP_BUY, 1, 0, 0, 0),
      row(CMD_POP_SELL, 0, 0, 0, 0), row(3'd7, 1, '1, '1, '1),
      row(CMD_POP_ASK, 0, 0, 0, 0), row(CMD_POP_BID, 0, 0, 0, 0),
      row(CMD_POP_BID, 0, 0, 0, 0)
    };
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_cmd(directed[i]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 6 : (ph == 1) ? 80 : 0;
      recv_idle = (ph == 0) ? 80 : (ph == 1) ? 6 : 0;
      k = 0;
      while (k < N_RANDOM / 3) begin
        // now and then fill one store or fifo to overflow
        if ($urandom_range(299) == 0) begin
          n_fill = $urandom_range(1) ? BOOK_N + 2 : MKT_N + 2;
          px_base = $urandom;
          fill_side = 1'($urandom_range(1));
          for (int j = 0; j < n_fill; j++) begin
            r = row(n_fill > MKT_N + 2 ? CMD_ADD_LIMIT : CMD_ADD_MARKET, fill_side,
                    $urandom, px_base + 32'($urandom_range(7)),
                    48'({$urandom, $urandom} >> 16));
            send_cmd(r);
          end
          k += n_fill;
          continue;
        end
        px_base = $urandom_range(3) == 0 ? $urandom : 32'd1000;
        r = row(3'($urandom_range(99) < 3 ? $urandom_range(7, 6) :
                (bids.size() + asks.size() > 200 ? $urandom_range(5, 2) : $urandom_range(5))),
                1'($urandom_range(1)), $urandom,
                px_base + 32'($urandom_range(15)) - 32'd8,
                $urandom_range(3) == 0 ? 48'({$urandom, $urandom} >> 16)
                                       : 48'($urandom_range(20)));
        send_cmd(r);
        k++;
      end
    end
    in_valid <= 0;

    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
